@@ hdl/ufr_pkg.sv @@
// Shared types and constants of the serial frame receiver.
// No dependencies; imported by ufr_rx_core and uart_frame_receiver.
package ufr_pkg;

   localparam int FIFO_DEPTH = 16;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int ADDR_W     = 5;
   localparam int DATA_W     = 32;

   typedef enum logic [2:0] {
      REG_DATA_BITS    = 3'd0,
      REG_PARITY_MODE  = 3'd1,
      REG_LINE_INVERT  = 3'd2,
      REG_BIT_INTERVAL = 3'd3,
      REG_FIRST_DELAY  = 3'd4
   } ufr_reg_type;

   localparam logic [1:0] PARITY_EVEN = 2'd1;
   localparam logic [1:0] PARITY_ODD  = 2'd2;

   typedef struct packed {
      logic [3:0]  data_bits;
      logic [1:0]  parity_mode;
      logic        line_invert;
      logic [15:0] bit_interval;
      logic [15:0] first_sample_delay;
   } ufr_cfg_type;

   localparam ufr_cfg_type CFG_RESET = '{
      data_bits:          4'd8,
      parity_mode:        2'd0,
      line_invert:        1'b0,
      bit_interval:       16'd16,
      first_sample_delay: 16'd21
   };

   // Receiver status produced on a line tick.
   typedef struct packed {
      logic       valid;
      logic       frame_done;
      logic       parity_error;
      logic       framing_error;
      logic       push;
      logic [7:0] data;
   } ufr_evt_type;

endpackage

@@ hdl/ufr_req_if.sv @@
// Input channel of the frame receiver: line ticks and host reads.
// No dependencies.
interface ufr_req_if;
   logic valid;
   logic ready;
   logic kind;
   logic line_level;

   modport source (output valid, output kind, output line_level, input ready);
   modport sink   (input valid, input kind, input line_level, output ready);
endinterface

@@ hdl/ufr_rsp_if.sv @@
// Result channel of the frame receiver: status events and read replies.
// No dependencies.
interface ufr_rsp_if;
   logic       valid;
   logic       ready;
   logic       reply_kind;
   logic [7:0] read_data;
   logic       read_empty;
   logic       frame_done;
   logic       parity_error;
   logic       framing_error;
   logic       overrun_error;
   logic       became_available;

   modport source (output valid, output reply_kind, output read_data, output read_empty,
                   output frame_done, output parity_error, output framing_error,
                   output overrun_error, output became_available, input ready);
   modport sink   (input valid, input reply_kind, input read_data, input read_empty,
                   input frame_done, input parity_error, input framing_error,
                   input overrun_error, input became_available, output ready);
endinterface

@@ hdl/ufr_rx_core.sv @@
// Bit sampler of the frame receiver: start detection, bit timing, shift
// register, parity and stop check. Depends on ufr_pkg.
module ufr_rx_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               tick,
   input  logic               line_level,
   input  ufr_pkg::ufr_cfg_type cfg,
   output ufr_pkg::ufr_evt_type evt
);
   import ufr_pkg::*;

   logic        rcv_ff, rcv_in;
   logic        prev_ff, prev_in;
   logic [15:0] cd_ff, cd_in;
   logic [3:0]  pos_ff, pos_in;
   logic [7:0]  shift_ff, shift_in;

   logic        level;
   logic        par_on;
   logic [3:0]  nbits;
   logic [15:0] interval;
   logic [15:0] delay;

   always_comb begin
      level    = line_level ^ cfg.line_invert;
      nbits    = (cfg.data_bits < 4'd7) ? 4'd7 : ((cfg.data_bits > 4'd8) ? 4'd8 : cfg.data_bits);
      interval = (cfg.bit_interval == 16'd0) ? 16'd1 : cfg.bit_interval;
      delay    = (cfg.first_sample_delay == 16'd0) ? 16'd1 : cfg.first_sample_delay;
      par_on   = (cfg.parity_mode == PARITY_EVEN) || (cfg.parity_mode == PARITY_ODD);

      rcv_in   = rcv_ff;
      prev_in  = prev_ff;
      cd_in    = cd_ff;
      pos_in   = pos_ff;
      shift_in = shift_ff;
      evt      = '0;
      evt.data = shift_ff;

      if (tick) begin
         prev_in = level;
         if (!rcv_ff) begin
            if (prev_ff && !level) begin
               rcv_in   = 1'b1;
               cd_in    = delay;
               pos_in   = 4'd0;
               shift_in = 8'd0;
            end
         end else if (cd_ff > 16'd1) begin
            cd_in = cd_ff - 16'd1;
         end else begin
            cd_in = interval;
            if (pos_ff < nbits) begin
               shift_in = shift_ff | (8'(level) << pos_ff[2:0]);
               pos_in   = pos_ff + 4'd1;
            end else if ((pos_ff == nbits) && par_on) begin
               pos_in = pos_ff + 4'd1;
               if (((^shift_ff) ^ level) != cfg.parity_mode[1]) begin
                  evt.valid        = 1'b1;
                  evt.parity_error = 1'b1;
               end
            end else begin
               evt.valid         = 1'b1;
               evt.frame_done    = 1'b1;
               evt.push          = level;
               evt.framing_error = !level;
               rcv_in            = 1'b0;
               cd_in             = 16'd0;
               pos_in            = 4'd0;
               shift_in          = 8'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rcv_ff   <= 1'b0;
         prev_ff  <= 1'b1;
         cd_ff    <= 16'd0;
         pos_ff   <= 4'd0;
         shift_ff <= 8'd0;
      end else begin
         rcv_ff   <= rcv_in;
         prev_ff  <= prev_in;
         cd_ff    <= cd_in;
         pos_ff   <= pos_in;
         shift_ff <= shift_in;
      end
   end

endmodule

@@ hdl/uart_frame_receiver.sv @@
// Top level of the serial frame receiver: register port, receive FIFO memory
// and result stages. Depends on ufr_pkg, ufr_req_if, ufr_rsp_if, ufr_rx_core.
//
//   channel | direction | beat carries
//   req     | in        | kind, line_level
//   rsp     | out       | reply_kind, read_data, read_empty, status flags
//   csr     | in/out    | APB-style register writes and reads
//
// One beat is taken per cycle while req.ready is high; a result passes the
// RAM-read stage, set by the registered FIFO RAM read, and the output register.
// Reset is synchronous; registers return to their defaults, FIFO empties.
// A stalled rsp holds its result; beats keep flowing until a second result
// waits in the RAM-read stage, then req.ready drops until rsp moves.
module uart_frame_receiver (
   input  logic                       clock,
   input  logic                       reset,
   ufr_req_if.sink                    req,
   ufr_rsp_if.source                  rsp,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [ufr_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [ufr_pkg::DATA_W-1:0] csr_pwdata,
   output logic [ufr_pkg::DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);
   import ufr_pkg::*;

   typedef struct packed {
      logic       reply_kind;
      logic       use_mem;
      logic       read_empty;
      logic       frame_done;
      logic       parity_error;
      logic       framing_error;
      logic       overrun_error;
      logic       became_available;
   } ufr_res_type;

   typedef struct packed {
      logic       reply_kind;
      logic [7:0] read_data;
      logic       read_empty;
      logic       frame_done;
      logic       parity_error;
      logic       framing_error;
      logic       overrun_error;
      logic       became_available;
   } ufr_out_type;

   ufr_cfg_type  cfg_ff, cfg_in;
   ufr_reg_type  reg_sel;
   logic         csr_wr;

   ufr_evt_type  evt;
   logic         acc, acc_rd, tick;
   logic         move_a;
   logic         rd_mem, wr_mem;

   logic [7:0]       mem [FIFO_DEPTH];
   logic [7:0]       q_ff;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic         a_v_ff, a_v_in;
   ufr_res_type  a_ff, a_in;
   logic         b_v_ff, b_v_in;
   ufr_out_type  b_ff, b_in;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = ufr_reg_type'(csr_paddr[4:2]);

   always_comb begin
      cfg_in     = cfg_ff;
      csr_prdata = '0;
      unique case (reg_sel)
         REG_DATA_BITS: begin
            csr_prdata = DATA_W'(cfg_ff.data_bits);
            if (csr_wr) cfg_in.data_bits = csr_pwdata[3:0];
         end
         REG_PARITY_MODE: begin
            csr_prdata = DATA_W'(cfg_ff.parity_mode);
            if (csr_wr) cfg_in.parity_mode = csr_pwdata[1:0];
         end
         REG_LINE_INVERT: begin
            csr_prdata = DATA_W'(cfg_ff.line_invert);
            if (csr_wr) cfg_in.line_invert = csr_pwdata[0];
         end
         REG_BIT_INTERVAL: begin
            csr_prdata = DATA_W'(cfg_ff.bit_interval);
            if (csr_wr) cfg_in.bit_interval = csr_pwdata[15:0];
         end
         REG_FIRST_DELAY: begin
            csr_prdata = DATA_W'(cfg_ff.first_sample_delay);
            if (csr_wr) cfg_in.first_sample_delay = csr_pwdata[15:0];
         end
         default: csr_prdata = '0;
      endcase
   end

   // handshake
   assign move_a    = a_v_ff && (!b_v_ff || rsp.ready);
   assign req.ready = !a_v_ff || move_a;
   assign acc       = req.valid && req.ready;
   assign acc_rd    = acc && req.kind;
   assign tick      = acc && !req.kind;

   ufr_rx_core u_core (
      .clock      (clock),
      .reset      (reset),
      .tick       (tick),
      .line_level (req.line_level),
      .cfg        (cfg_ff),
      .evt        (evt)
   );

   // FIFO pointers; a read and a push never fall in the same cycle
   assign rd_mem = acc_rd && (cnt_ff != '0);
   assign wr_mem = evt.valid && evt.push && (cnt_ff != CNT_W'(FIFO_DEPTH));

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in  = cnt_ff;
      if (rd_mem) begin
         head_in = (head_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
         cnt_in  = cnt_ff - CNT_W'(1);
      end
      if (wr_mem) begin
         tail_in = (tail_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
         cnt_in  = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_mem) mem[tail_ff] <= evt.data;
      if (rd_mem) q_ff <= mem[head_ff];
   end

   // RAM-read stage and output register
   always_comb begin
      a_v_in = a_v_ff;
      a_in   = a_ff;
      if (acc_rd) begin
         a_v_in                = 1'b1;
         a_in                  = '0;
         a_in.reply_kind       = 1'b1;
         a_in.use_mem          = (cnt_ff != '0);
         a_in.read_empty       = (cnt_ff == '0);
      end else if (tick && evt.valid) begin
         a_v_in                = 1'b1;
         a_in                  = '0;
         a_in.frame_done       = evt.frame_done;
         a_in.parity_error     = evt.parity_error;
         a_in.framing_error    = evt.framing_error;
         a_in.overrun_error    = evt.push && (cnt_ff == CNT_W'(FIFO_DEPTH));
         a_in.became_available = evt.push && (cnt_ff == '0);
      end else if (move_a) begin
         a_v_in = 1'b0;
      end

      b_v_in = b_v_ff;
      b_in   = b_ff;
      if (move_a) begin
         b_v_in                = 1'b1;
         b_in.reply_kind       = a_ff.reply_kind;
         b_in.read_data        = a_ff.use_mem ? q_ff : 8'd0;
         b_in.read_empty       = a_ff.read_empty;
         b_in.frame_done       = a_ff.frame_done;
         b_in.parity_error     = a_ff.parity_error;
         b_in.framing_error    = a_ff.framing_error;
         b_in.overrun_error    = a_ff.overrun_error;
         b_in.became_available = a_ff.became_available;
      end else if (rsp.ready) begin
         b_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff  <= CFG_RESET;
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
         a_v_ff  <= 1'b0;
         b_v_ff  <= 1'b0;
      end else begin
         cfg_ff  <= cfg_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
         a_v_ff  <= a_v_in;
         b_v_ff  <= b_v_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign rsp.valid            = b_v_ff;
   assign rsp.reply_kind       = b_ff.reply_kind;
   assign rsp.read_data        = b_ff.read_data;
   assign rsp.read_empty       = b_ff.read_empty;
   assign rsp.frame_done       = b_ff.frame_done;
   assign rsp.parity_error     = b_ff.parity_error;
   assign rsp.framing_error    = b_ff.framing_error;
   assign rsp.overrun_error    = b_ff.overrun_error;
   assign rsp.became_available = b_ff.became_available;

   // checks
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty FIFO with head and tail apart");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (acc_rd && (cnt_ff != '0)) |=> (cnt_ff + CNT_W'(1) == $past(cnt_ff)))
      else $error("read beat did not pop the FIFO");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (evt.valid && evt.push && (cnt_ff == CNT_W'(FIFO_DEPTH)))
      |=> (cnt_ff == CNT_W'(FIFO_DEPTH)) && a_v_ff && a_ff.overrun_error)
      else $error("push into full FIFO not flagged as overrun");

endmodule
